### rtl/core/rrt_pkg.sv
// Shared types, codes and constants of the request retry table.
package rrt_pkg;

    localparam int ENTRY_COUNT   = 8;
    localparam int IDX_W         = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int PAYLOAD_BYTES = 20;
    localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;
    localparam int LEN_W         = 5;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_COUNT - 1);
    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(PAYLOAD_BYTES);

    // item function codes
    localparam logic [1:0] FN_REQUEST  = 2'd0;
    localparam logic [1:0] FN_RESPONSE = 2'd1;
    localparam logic [1:0] FN_TICK     = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_IGNORED = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_NONE    = 2'd3;

    // entry phases
    localparam logic [1:0] PH_FREE    = 2'd0;
    localparam logic [1:0] PH_PENDING = 2'd1;
    localparam logic [1:0] PH_WAITING = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_LOCAL_SUBNET    = 2'd0;
    localparam logic [1:0] CFG_LOCAL_DEVICE    = 2'd1;
    localparam logic [1:0] CFG_RESEND_INTERVAL = 2'd2;
    localparam logic [1:0] CFG_RETRY_LIMIT     = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [7:0] local_subnet;
        logic [7:0] local_device;
        logic [7:0] resend_interval;
        logic [3:0] retry_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]           func;
        logic [15:0]          command;
        logic [7:0]           subnet;
        logic [7:0]           device;
        logic [LEN_W-1:0]     length;
        logic [PAYLOAD_W-1:0] payload;
        logic                 send_ok;
    } item_t;

    typedef struct packed {
        logic [1:0]           phase;
        logic [3:0]           retries;
        logic [7:0]           timer;
        logic [15:0]          command;
        logic [7:0]           subnet;
        logic [7:0]           device;
        logic [LEN_W-1:0]     length;
        logic [PAYLOAD_W-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic [1:0]           status;
        logic                 send_valid;
        logic                 channel;
        logic [15:0]          command;
        logic [7:0]           subnet;
        logic [7:0]           device;
        logic [LEN_W-1:0]     length;
        logic [PAYLOAD_W-1:0] payload;
    } result_t;

    // keeps the bytes below len
    function automatic logic [PAYLOAD_W-1:0] payload_mask(input logic [LEN_W-1:0] len);
        logic [PAYLOAD_W-1:0] m;
        m = '0;
        for (int b = 0; b < PAYLOAD_BYTES; b++)
        begin
            m[8*b +: 8] = {8{LEN_W'(b) < len}};
        end
        return m;
    endfunction

endpackage

### rtl/core/rrt_engine.sv
// Entry table memory and the sequencer that scans it for one item.
module rrt_engine
    import rrt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    start,
    input  item_t   item,
    input  logic    out_free,
    output logic    busy,
    output logic    res_valid,
    output result_t res
);

    entry_t mem [ENTRY_COUNT];
    entry_t mem_q;

    state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [ENTRY_COUNT-1:0] valid_reg, valid_next;
    item_t   item_reg, item_next;
    result_t res_reg, res_next;

    logic [IDX_W-1:0] raddr;
    logic             mem_we;
    entry_t           mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= mem_wdata;
        end
        mem_q <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        entry_t     cur;
        logic       stop;
        logic [7:0] t;
        logic [4:0] retry_cnt;

        state_next = state_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        item_next  = item_reg;
        res_next   = res_reg;
        raddr      = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
        mem_we     = 1'b0;
        busy       = 1'b1;
        res_valid  = 1'b0;
        stop       = 1'b0;
        t          = '0;
        retry_cnt  = '0;

        // untouched entries read as free
        cur = mem_q;
        if (!valid_reg[idx_reg])
        begin
            cur.phase   = PH_FREE;
            cur.retries = '0;
            cur.timer   = '0;
        end
        mem_wdata = cur;

        case (state_reg)
            ST_IDLE:
            begin
                busy  = 1'b0;
                raddr = '0;
                if (start)
                begin
                    item_next = item;
                    idx_next  = '0;
                    res_next  = '0;
                    case (item.func)
                        FN_REQUEST:
                        begin
                            if (item.subnet == cfg.local_subnet &&
                                item.device == cfg.local_device)
                            begin
                                res_next.status = STAT_IGNORED;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                res_next.status = STAT_FULL;
                                state_next      = ST_SCAN;
                            end
                        end
                        FN_RESPONSE:
                        begin
                            res_next.status = STAT_DONE;
                            state_next      = ST_SCAN;
                        end
                        FN_TICK:
                        begin
                            res_next.status = STAT_NONE;
                            state_next      = ST_SCAN;
                        end
                        default:
                        begin
                            res_next.status = STAT_NONE;
                            state_next      = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                case (item_reg.func)
                    FN_REQUEST:
                    begin
                        if (cur.phase == PH_FREE)
                        begin
                            mem_we            = 1'b1;
                            mem_wdata.phase   = PH_PENDING;
                            mem_wdata.retries = '0;
                            mem_wdata.timer   = cfg.resend_interval;
                            mem_wdata.command = item_reg.command;
                            mem_wdata.subnet  = item_reg.subnet;
                            mem_wdata.device  = item_reg.device;
                            mem_wdata.length  = item_reg.length;
                            mem_wdata.payload = item_reg.payload;
                            res_next.status   = STAT_DONE;
                            stop              = 1'b1;
                        end
                    end
                    FN_RESPONSE:
                    begin
                        if (cur.phase == PH_WAITING && cur.command == item_reg.command &&
                            cur.subnet == item_reg.subnet && cur.device == item_reg.device)
                        begin
                            mem_we            = 1'b1;
                            mem_wdata.phase   = PH_FREE;
                            mem_wdata.retries = '0;
                            mem_wdata.timer   = '0;
                        end
                    end
                    FN_TICK:
                    begin
                        if (cur.phase != PH_FREE)
                        begin
                            mem_we = 1'b1;
                            t = (cur.timer != 8'hFF) ? cur.timer + 8'd1 : cur.timer;
                            if (t < cfg.resend_interval)
                            begin
                                mem_wdata.timer = t;
                            end
                            else
                            begin
                                mem_wdata.timer = '0;
                                stop            = 1'b1;
                                if (item_reg.send_ok)
                                begin
                                    res_next.status     = STAT_DONE;
                                    res_next.send_valid = 1'b1;
                                    res_next.channel    = (cur.subnet != cfg.local_subnet);
                                    res_next.command    = cur.command;
                                    res_next.subnet     = cur.subnet;
                                    res_next.device     = cur.device;
                                    res_next.length     = cur.length;
                                    res_next.payload    = cur.payload;
                                    retry_cnt = {1'b0, cur.retries} + 5'd1;
                                    if (retry_cnt > {1'b0, cfg.retry_limit})
                                    begin
                                        mem_wdata.phase   = PH_FREE;
                                        mem_wdata.retries = '0;
                                    end
                                    else
                                    begin
                                        mem_wdata.phase   = PH_WAITING;
                                        mem_wdata.retries = retry_cnt[3:0];
                                    end
                                end
                            end
                        end
                    end
                    default:
                    begin
                        stop = 1'b1;
                    end
                endcase

                if (mem_we)
                begin
                    valid_next[idx_reg] = 1'b1;
                end
                if (stop || idx_reg == LAST_IDX)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

### rtl/core/request_retry_table_top.sv
// Request retry table: stream ports, configuration registers and output register.
// An item is accepted in the idle state; its scan reads one table entry per cycle
// from the entry memory, up to all 8 entries (none for a request to the local device),
// then hands over the result; a new item is accepted only after that hand-over.
// Reset (rst_n low, asynchronous) frees every entry at once through per-entry valid
// bits and loads the register defaults; no clearing pass.
module request_retry_table_top
    import rrt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command, target_subnet, target_device, payload_length, payload_low,
    // payload_mid, payload_high, send_ok, zero fill
    input  logic [199:0] s_axis_tdata,
    // func
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // send_valid, send_channel, send_command, send_subnet, send_device, send_length,
    // send_payload_low, send_payload_mid, send_payload_high, zero fill
    output logic [199:0] m_axis_tdata,
    // status
    output logic [1:0]   m_axis_tuser
);

    cfg_t    cfg_reg;
    item_t   item;
    result_t res;
    result_t out_reg;
    logic    out_valid_reg;
    logic    busy;
    logic    res_valid;
    logic    out_free;
    logic    start;
    logic [LEN_W-1:0] len_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.local_subnet    <= 8'd1;
            cfg_reg.local_device    <= 8'd1;
            cfg_reg.resend_interval <= 8'd50;
            cfg_reg.retry_limit     <= 4'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LOCAL_SUBNET:    cfg_reg.local_subnet    <= cfg_wdata;
                CFG_LOCAL_DEVICE:    cfg_reg.local_device    <= cfg_wdata;
                CFG_RESEND_INTERVAL: cfg_reg.resend_interval <= cfg_wdata;
                CFG_RETRY_LIMIT:     cfg_reg.retry_limit     <= cfg_wdata[3:0];
                default:             cfg_reg.retry_limit     <= cfg_reg.retry_limit;
            endcase
        end
    end

    assign len_sat = (s_axis_tdata[36:32] > LEN_MAX) ? LEN_MAX : s_axis_tdata[36:32];

    always_comb
    begin
        item.func    = s_axis_tuser;
        item.command = s_axis_tdata[15:0];
        item.subnet  = s_axis_tdata[23:16];
        item.device  = s_axis_tdata[31:24];
        item.length  = len_sat;
        item.payload = s_axis_tdata[196:37] & payload_mask(len_sat);
        item.send_ok = s_axis_tdata[197];
    end

    assign s_axis_tready = !busy;
    assign start         = s_axis_tvalid && !busy;
    assign out_free      = !out_valid_reg || m_axis_tready;

    rrt_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .start     (start),
        .item      (item),
        .out_free  (out_free),
        .busy      (busy),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {1'b0, out_reg.payload, out_reg.length, out_reg.device,
                            out_reg.subnet, out_reg.command, out_reg.channel,
                            out_reg.send_valid};

endmodule
